>>> rtl/core/c80alu_pkg.sv
// Shared types, operation codes and helpers for the 8080-style ALU.
package c80alu_pkg;

    localparam int MODE_W = 5;
    localparam int BYTE_W = 8;

    localparam logic [MODE_W-1:0] OP_ADD  = 5'd0;
    localparam logic [MODE_W-1:0] OP_ADC  = 5'd1;
    localparam logic [MODE_W-1:0] OP_SUB  = 5'd2;
    localparam logic [MODE_W-1:0] OP_SBB  = 5'd3;
    localparam logic [MODE_W-1:0] OP_AND  = 5'd4;
    localparam logic [MODE_W-1:0] OP_XOR  = 5'd5;
    localparam logic [MODE_W-1:0] OP_OR   = 5'd6;
    localparam logic [MODE_W-1:0] OP_CMP  = 5'd7;
    localparam logic [MODE_W-1:0] OP_INC  = 5'd8;
    localparam logic [MODE_W-1:0] OP_DEC  = 5'd9;
    localparam logic [MODE_W-1:0] OP_RLC  = 5'd10;
    localparam logic [MODE_W-1:0] OP_RRC  = 5'd11;
    localparam logic [MODE_W-1:0] OP_RAL  = 5'd12;
    localparam logic [MODE_W-1:0] OP_RAR  = 5'd13;
    localparam logic [MODE_W-1:0] OP_DAA  = 5'd14;
    localparam logic [MODE_W-1:0] OP_CMA  = 5'd15;
    localparam logic [MODE_W-1:0] OP_CMC  = 5'd16;
    localparam logic [MODE_W-1:0] OP_STC  = 5'd17;
    localparam logic [MODE_W-1:0] OP_LOAD = 5'd18;

    localparam logic [3:0] BCD_LIMIT = 4'h9;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;

    // Flag byte bit positions
    localparam int FLAG_S  = 7;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_AC = 4;
    localparam int FLAG_P  = 2;
    localparam int FLAG_ONE = 1;
    localparam int FLAG_CY = 0;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic              sign;
        logic              zero;
        logic              aux;
        logic              parity;
        logic              carry;
    } alu_state_t;

    function automatic logic [BYTE_W-1:0] pack_flags(input alu_state_t st);
        logic [BYTE_W-1:0] f;
        f = '0;
        f[FLAG_S]   = st.sign;
        f[FLAG_Z]   = st.zero;
        f[FLAG_AC]  = st.aux;
        f[FLAG_P]   = st.parity;
        f[FLAG_ONE] = 1'b1;
        f[FLAG_CY]  = st.carry;
        return f;
    endfunction

endpackage

>>> rtl/core/c80alu_core.sv
// Combinational ALU: one operation applied to the accumulator and flags.
module c80alu_core
    import c80alu_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  logic [BYTE_W-1:0] operand,
    input  alu_state_t        state,
    output logic [BYTE_W-1:0] result,
    output alu_state_t        state_next
);

    logic [BYTE_W-1:0] add_b;
    logic              add_cin;
    logic [BYTE_W:0]   add_sum;
    logic [4:0]        add_low;
    logic [BYTE_W-1:0] inc_val;
    logic [BYTE_W-1:0] dec_val;
    logic [3:0]        lo;
    logic [3:0]        hi;
    logic [BYTE_W-1:0] corr;
    logic              daa_cy;
    logic [BYTE_W-1:0] daa_val;
    logic [4:0]        daa_low;
    logic              is_sub;

    // Shared adder; subtraction adds the complemented operand with inverted borrow
    always_comb
    begin
        is_sub = (mode == OP_SUB) || (mode == OP_SBB) || (mode == OP_CMP);
        add_b  = is_sub ? ~operand : operand;
        unique case (mode)
            OP_ADC:  add_cin = state.carry;
            OP_SUB:  add_cin = 1'b1;
            OP_CMP:  add_cin = 1'b1;
            OP_SBB:  add_cin = ~state.carry;
            default: add_cin = 1'b0;
        endcase
        add_sum = {1'b0, state.acc} + {1'b0, add_b} + {{BYTE_W{1'b0}}, add_cin};
        add_low = {1'b0, state.acc[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
    end

    // Decimal adjust
    always_comb
    begin
        lo = state.acc[3:0];
        hi = state.acc[7:4];
        corr = '0;
        daa_cy = state.carry;
        if ((lo > BCD_LIMIT) || state.aux)
            corr = corr | DAA_LO_ADJ;
        if ((hi > BCD_LIMIT) || state.carry || ((hi >= BCD_LIMIT) && (lo > BCD_LIMIT)))
        begin
            corr = corr | DAA_HI_ADJ;
            daa_cy = 1'b1;
        end
        daa_low = {1'b0, lo} + {1'b0, corr[3:0]};
        daa_val = state.acc + corr;
    end

    assign inc_val = operand + 8'd1;
    assign dec_val = operand - 8'd1;

    always_comb
    begin
        result     = state.acc;
        state_next = state;
        unique case (mode)
            OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP:
            begin
                result           = add_sum[BYTE_W-1:0];
                state_next.carry = add_sum[BYTE_W] ^ is_sub;
                state_next.aux   = add_low[4];
                if (mode != OP_CMP)
                    state_next.acc = result;
            end
            OP_AND:
            begin
                result           = state.acc & operand;
                state_next.acc   = result;
                state_next.carry = 1'b0;
                state_next.aux   = state.acc[3] | operand[3];
            end
            OP_XOR, OP_OR:
            begin
                result           = (mode == OP_XOR) ? (state.acc ^ operand)
                                                    : (state.acc | operand);
                state_next.acc   = result;
                state_next.carry = 1'b0;
                state_next.aux   = 1'b0;
            end
            OP_INC:
            begin
                result         = inc_val;
                state_next.aux = (operand[3:0] == 4'hf);
            end
            OP_DEC:
            begin
                result         = dec_val;
                state_next.aux = (operand[3:0] != 4'h0);
            end
            OP_RLC:
            begin
                result           = {state.acc[6:0], state.acc[7]};
                state_next.acc   = result;
                state_next.carry = state.acc[7];
            end
            OP_RRC:
            begin
                result           = {state.acc[0], state.acc[7:1]};
                state_next.acc   = result;
                state_next.carry = state.acc[0];
            end
            OP_RAL:
            begin
                result           = {state.acc[6:0], state.carry};
                state_next.acc   = result;
                state_next.carry = state.acc[7];
            end
            OP_RAR:
            begin
                result           = {state.carry, state.acc[7:1]};
                state_next.acc   = result;
                state_next.carry = state.acc[0];
            end
            OP_DAA:
            begin
                result           = daa_val;
                state_next.acc   = result;
                state_next.carry = daa_cy;
                state_next.aux   = daa_low[4];
            end
            OP_CMA:
            begin
                result         = ~state.acc;
                state_next.acc = result;
            end
            OP_CMC:  state_next.carry = ~state.carry;
            OP_STC:  state_next.carry = 1'b1;
            OP_LOAD:
            begin
                result         = operand;
                state_next.acc = result;
            end
            default: ;
        endcase

        // Sign, zero and parity follow the result for arithmetic, logic, inc/dec and daa
        if ((mode <= OP_DEC) || (mode == OP_DAA))
        begin
            state_next.sign   = result[BYTE_W-1];
            state_next.zero   = (result == '0);
            state_next.parity = ~^result;
        end
    end

endmodule

>>> rtl/core/cpu8080_alu_with_flags_top.sv
// Top level of the 8080-style ALU with accumulator and flag registers.
// One operation per clock: a transaction is accepted every cycle while the result side
// keeps taking results; each item goes from the input register through one pass of the
// ALU into the result register. The rate is set by the combinational ALU path from the
// accumulator and flag registers back into themselves. Input: s_tuser carries the
// operation code, s_tdata the operand byte. Output m_tdata carries the result byte, the
// accumulator after the operation and the packed flag byte (S bit 7, Z bit 6, AC bit 4,
// P bit 2, bit 1 always set, CY bit 0). Reset clears the accumulator and all flags.
module cpu8080_alu_with_flags_top
    import c80alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] operand
    input  logic [7:0]  s_tuser,    // [4:0] mode, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [7:0] result, [15:8] accumulator_out, [23:16] flag_byte
);

    logic              in_valid_reg;
    logic [MODE_W-1:0] in_mode_reg;
    logic [BYTE_W-1:0] in_operand_reg;
    alu_state_t        state_reg;
    alu_state_t        state_next;
    logic [BYTE_W-1:0] alu_result;
    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic              advance;
    logic              s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    c80alu_core u_core
    (
        .mode       (in_mode_reg),
        .operand    (in_operand_reg),
        .state      (state_reg),
        .result     (alu_result),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_mode_reg    <= s_tuser[MODE_W-1:0];
            in_operand_reg <= s_tdata;
        end
        if (advance)
            out_data_reg <= {pack_flags(state_next), state_next.acc, alu_result};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Fixed flag byte bits
    a_flag_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16+FLAG_ONE] && !m_tdata[21] && !m_tdata[19]))
        else $error("flag byte fixed bits wrong");

    // The held accumulator and flag fields always mirror the architectural state
    a_state_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:8] == state_reg.acc &&
                      m_tdata[23:16] == pack_flags(state_reg)))
        else $error("output does not match accumulator and flags");

    // A transaction moved into the result register shows up next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after advance");

    // A stalled input item is kept
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_mode_reg) &&
                                        $stable(in_operand_reg)))
        else $error("stalled input item dropped");

    // State only changes when an item passes through the ALU
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

endmodule

>>> tb/tb_cpu8080_alu_with_flags_top.sv
// Self-checking testbench for the 8080-style ALU with accumulator and flags.
`timescale 1ns / 100ps

module tb_cpu8080_alu_with_flags_top;
    import c80alu_pkg::*;

    localparam int RANDOM_OPS   = 1150;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_N        = 25;

    // codes outside the defined set must leave all state alone
    localparam logic [MODE_W-1:0] OP_UNKNOWN_LO = 5'd19;
    localparam logic [MODE_W-1:0] OP_UNKNOWN_HI = 5'd31;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        opnd;
        logic              typed;    // use the typed-in value below instead of the predictor
        logic [23:0]       want;     // {flag_byte, accumulator_out, result}
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] operand
    logic [7:0]  s_tuser = '0;     // [4:0] mode, [7:5] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [7:0] result, [15:8] accumulator_out, [23:16] flag_byte

    alu_state_t  model_st;
    logic [23:0] expected_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    stim_row_t dir_rows [0:DIR_N-1] = '{
        '{OP_CMC,        8'h00, 1'b1, 24'h030000},
        '{OP_LOAD,       8'hFF, 1'b1, 24'h03FFFF},
        '{OP_ADD,        8'h01, 1'b1, 24'h570000},
        '{OP_ADC,        8'hFF, 1'b0, 24'h0},
        '{OP_LOAD,       8'h80, 1'b0, 24'h0},
        '{OP_SUB,        8'h01, 1'b0, 24'h0},
        '{OP_SBB,        8'h00, 1'b0, 24'h0},
        '{OP_SBB,        8'hFF, 1'b0, 24'h0},
        '{OP_CMP,        8'h7F, 1'b0, 24'h0},
        '{OP_AND,        8'h08, 1'b0, 24'h0},
        '{OP_XOR,        8'hF0, 1'b0, 24'h0},
        '{OP_OR,         8'h00, 1'b0, 24'h0},
        '{OP_INC,        8'hFF, 1'b0, 24'h0},
        '{OP_DEC,        8'h00, 1'b0, 24'h0},
        '{OP_RLC,        8'h00, 1'b0, 24'h0},
        '{OP_RRC,        8'hFF, 1'b0, 24'h0},
        '{OP_RAL,        8'h55, 1'b0, 24'h0},
        '{OP_RAR,        8'hAA, 1'b0, 24'h0},
        '{OP_LOAD,       8'h9A, 1'b0, 24'h0},
        '{OP_DAA,        8'h00, 1'b0, 24'h0},
        '{OP_STC,        8'h00, 1'b0, 24'h0},
        '{OP_DAA,        8'h00, 1'b0, 24'h0},
        '{OP_CMA,        8'h00, 1'b0, 24'h0},
        '{OP_UNKNOWN_LO, 8'hFF, 1'b0, 24'h0},
        '{OP_UNKNOWN_HI, 8'h00, 1'b0, 24'h0}
    };

    cpu8080_alu_with_flags_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic void set_szp(input logic [7:0] r);
        model_st.sign   = r[7];
        model_st.zero   = (r == 8'h00);
        model_st.parity = ~^r;
    endfunction

    function automatic logic [7:0] add_update(input logic [7:0] a, input logic [7:0] b,
                                              input logic cin);
        logic [8:0] sum;
        logic [4:0] low;
        sum = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        low = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        model_st.carry = sum[8];
        model_st.aux   = low[4];
        set_szp(sum[7:0]);
        return sum[7:0];
    endfunction

    // subtract as a + ~b + ~borrow_in; carry then means borrow
    function automatic logic [7:0] sub_update(input logic [7:0] a, input logic [7:0] b,
                                              input logic bin);
        logic [7:0] r;
        r = add_update(a, ~b, ~bin);
        model_st.carry = ~model_st.carry;
        return r;
    endfunction

    function automatic logic [23:0] alu_predict(input logic [MODE_W-1:0] mode,
                                                input logic [7:0] opnd);
        logic [7:0] a;
        logic [7:0] res;
        logic       cy;
        logic [3:0] lo;
        logic [3:0] hi;
        logic [7:0] corr;
        logic       new_cy;
        logic [4:0] lo_sum;
        logic [7:0] flags;
        a   = model_st.acc;
        res = a;
        cy  = model_st.carry;
        case (mode)
            OP_ADD: begin res = add_update(a, opnd, 1'b0); model_st.acc = res; end
            OP_ADC: begin res = add_update(a, opnd, cy);   model_st.acc = res; end
            OP_SUB: begin res = sub_update(a, opnd, 1'b0); model_st.acc = res; end
            OP_SBB: begin res = sub_update(a, opnd, cy);   model_st.acc = res; end
            OP_AND:
            begin
                res = a & opnd;
                set_szp(res);
                model_st.carry = 1'b0;
                model_st.aux   = a[3] | opnd[3];
                model_st.acc   = res;
            end
            OP_XOR, OP_OR:
            begin
                res = (mode == OP_XOR) ? (a ^ opnd) : (a | opnd);
                set_szp(res);
                model_st.carry = 1'b0;
                model_st.aux   = 1'b0;
                model_st.acc   = res;
            end
            OP_CMP: res = sub_update(a, opnd, 1'b0);
            OP_INC:
            begin
                res = opnd + 8'h01;
                set_szp(res);
                model_st.aux = (opnd[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                res = opnd - 8'h01;
                set_szp(res);
                model_st.aux = (opnd[3:0] != 4'h0);
            end
            OP_RLC: begin model_st.carry = a[7]; res = {a[6:0], a[7]}; model_st.acc = res; end
            OP_RRC: begin model_st.carry = a[0]; res = {a[0], a[7:1]}; model_st.acc = res; end
            OP_RAL: begin model_st.carry = a[7]; res = {a[6:0], cy};   model_st.acc = res; end
            OP_RAR: begin model_st.carry = a[0]; res = {cy, a[7:1]};   model_st.acc = res; end
            OP_DAA:
            begin
                lo = a[3:0];
                hi = a[7:4];
                corr = 8'h00;
                new_cy = cy;
                if (lo > BCD_LIMIT || model_st.aux)
                    corr = corr | DAA_LO_ADJ;
                if (hi > BCD_LIMIT || cy || (hi >= BCD_LIMIT && lo > BCD_LIMIT))
                begin
                    corr = corr | DAA_HI_ADJ;
                    new_cy = 1'b1;
                end
                lo_sum = {1'b0, lo} + {1'b0, corr[3:0]};
                model_st.aux = lo_sum[4];
                res = a + corr;
                set_szp(res);
                model_st.carry = new_cy;
                model_st.acc = res;
            end
            OP_CMA:  begin res = ~a;  model_st.acc = res; end
            OP_CMC:  model_st.carry = ~cy;
            OP_STC:  model_st.carry = 1'b1;
            OP_LOAD: begin res = opnd; model_st.acc = res; end
            default: ;
        endcase
        flags = {model_st.sign, model_st.zero, 1'b0, model_st.aux,
                 1'b0, model_st.parity, 1'b1, model_st.carry};
        return {flags, model_st.acc, res};
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'hF0;
            4: return 8'h80;
            5: return 8'h7F;
            6: return 8'h99;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [7:0] opnd,
                           input logic typed, input logic [23:0] want);
        int          gap;
        logic [23:0] pred;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {3'b000, mode};
        s_tdata  <= opnd;
        do @(posedge clk); while (!s_tready);
        pred = alu_predict(mode, opnd);
        expected_q.push_back(typed ? want : pred);
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        model_st = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_op(dir_rows[i].mode, dir_rows[i].opnd, dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 100 == 0)
                send_burst = ($urandom_range(3) == 0);
            // let the pipeline run dry once mid-stream
            if (i == RANDOM_OPS / 2)
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (expected_q.size() != 0);
            end
            if ($urandom_range(9) == 0)
                mode = MODE_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            else
                mode = MODE_W'($urandom_range(OP_ADD, OP_LOAD));
            send_op(mode, pick_operand(), 1'b0, 24'h0);
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result-side backpressure, with stretches of steady ready
    initial
    begin
        int ready_len;
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(19) == 0)
                recv_burst = ~recv_burst;
            ready_len = $urandom_range(1, 6);
            m_tready <= 1'b1;
            repeat (ready_len) @(posedge clk);
            stall = recv_burst ? 0 : pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        logic [23:0] exp_val;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected transaction: res=%h acc=%h flags=%h",
                             m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
            end
            else
            begin
                exp_val = expected_q.pop_front();
                if (m_tdata[7:0] !== exp_val[7:0] || m_tdata[15:8] !== exp_val[15:8] ||
                    m_tdata[23:16] !== exp_val[23:16])
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: exp res=%h acc=%h flags=%h, got res=%h acc=%h flags=%h",
                                 exp_val[7:0], exp_val[15:8], exp_val[23:16],
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
